// ===== sv/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Types, command and segment codes and line-program tables shared by the
// bit-level I2C master files.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int MODE_W        = 3;
	localparam int HALF_W        = 16;
	localparam int BIDX_W        = $clog2(BITS_PER_BYTE);
	localparam logic [BIDX_W-1:0] LAST_BIT = BIDX_W'(BITS_PER_BYTE - 1);
	localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(5);

	// phase 0 is idle, otherwise 1 + segment index in the command program
	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PHASE_IDLE    = '0;
	localparam logic [PHASE_W-1:0] PHASE_MAX_SEG = PHASE_W'(5);

	typedef enum logic [MODE_W-1:0] {
		CMD_START = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_WACK  = 3'd4,
		CMD_ACK   = 3'd5,
		CMD_NACK  = 3'd6,
		CMD_CHECK = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		SEG_START = 3'd0,
		SEG_STOP  = 3'd1,
		SEG_SEND  = 3'd2,
		SEG_READ  = 3'd3,
		SEG_WACK  = 3'd4,
		SEG_ACK   = 3'd5,
		SEG_NACK  = 3'd6
	} seg_t;

	// one result transaction
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_status;
	} res_t;

	// segment that runs in a given phase of a command
	function automatic seg_t cur_seg(cmd_t cmd, logic [PHASE_W-1:0] phase);
		seg_t s;
		s = SEG_NACK;
		if (phase != PHASE_IDLE && phase <= PHASE_MAX_SEG) begin
			case (cmd)
				CMD_START: s = SEG_START;
				CMD_STOP:  s = SEG_STOP;
				CMD_WRITE: s = SEG_SEND;
				CMD_READ:  s = SEG_READ;
				CMD_WACK:  s = SEG_WACK;
				CMD_ACK:   s = SEG_ACK;
				CMD_NACK:  s = SEG_NACK;
				default: begin
					// check device: stop, start, address write, ack sample, stop
					case (phase)
						3'd1:    s = SEG_STOP;
						3'd2:    s = SEG_START;
						3'd3:    s = SEG_SEND;
						3'd4:    s = SEG_WACK;
						default: s = SEG_STOP;
					endcase
				end
			endcase
		end
		return s;
	endfunction

	function automatic logic [PHASE_W-1:0] prog_len(cmd_t cmd);
		return (cmd == CMD_CHECK) ? PHASE_MAX_SEG : PHASE_W'(1);
	endfunction

	function automatic logic [1:0] seg_steps(seg_t s);
		return (s == SEG_STOP) ? 2'd1 : (s == SEG_READ) ? 2'd2 : 2'd3;
	endfunction

endpackage

// ===== sv/i2cbm_if.sv =====
// ----------------------------------------------------------------------------
// i2cbm tick and result channels
// Valid/ready channels carrying one tick in and one line/status result out.
// ----------------------------------------------------------------------------
interface i2cbm_tick_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd_valid;
	logic [i2cbm_pkg::MODE_W-1:0]  mode;
	logic [7:0]                    data;
	logic                          sda_in;

	modport source (output valid, cmd_valid, mode, data, sda_in, input ready);
	modport sink   (input valid, cmd_valid, mode, data, sda_in, output ready);
endinterface

interface i2cbm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;
	logic       ack_status;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, read_byte,
		ack_status, input ready);
	modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_byte,
		ack_status, output ready);
endinterface

// ===== sv/i2c_bit_level_master_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_level_master_unit
// Bit-level I2C master: one tick transaction in, one line/status result out.
// ----------------------------------------------------------------------------
// Each tick transaction is accepted and its result (SCL, SDA
// drive, busy, done, read byte, ack status) appears in the result register on
// the next clock; a new tick can be taken every cycle, including the cycle in
// which the previous result is taken, as the sequencer state advances once per
// tick. Throughput is bounded only by the result sink: tick.ready drops while a
// result is held and result.ready is low. cfg_wdata sets the number of ticks
// each line phase is held (0 acts as 1, reset value 5).
module i2c_bit_level_master_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [i2cbm_pkg::HALF_W-1:0] cfg_wdata,
	i2cbm_tick_if.sink                   tick,
	i2cbm_res_if.source                  result
);
	import i2cbm_pkg::*;

	logic accept;
	logic can_load;
	res_t res_d;

	assign tick.ready = can_load;
	assign accept     = tick.valid && can_load;

	i2cbm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd_valid (tick.cmd_valid),
		.mode      (tick.mode),
		.data      (tick.data),
		.sda_in    (tick.sda_in),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.res_d     (res_d)
	);

	i2cbm_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res_d    (res_d),
		.can_load (can_load),
		.result   (result)
	);

endmodule

// ===== sv/i2cbm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cbm_seq
// Line sequencer: command state, hold counter, shift register and line
// levels, advanced once per accepted tick; also holds the hold-length register.
// ----------------------------------------------------------------------------
module i2cbm_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         cmd_valid,
	input  logic [i2cbm_pkg::MODE_W-1:0] mode,
	input  logic [7:0]                   data,
	input  logic                         sda_in,
	input  logic                         cfg_wen,
	input  logic [i2cbm_pkg::HALF_W-1:0] cfg_wdata,
	output i2cbm_pkg::res_t              res_d
);
	import i2cbm_pkg::*;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic [7:0] shift;
	} line_t;

	logic [HALF_W-1:0]  half_q;
	cmd_t               cmd_q, cmd_n;
	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [1:0]         sub_q, sub_n;
	logic [BIDX_W-1:0]  bidx_q, bidx_n;
	logic [HALF_W-1:0]  tick_q, tick_n;
	line_t              line_q, line_n;
	logic               ack_q, ack_n;
	logic [7:0]         rd_q, rd_n;
	logic               done;
	logic [HALF_W-1:0]  hold_m1;
	seg_t               seg;
	logic [1:0]         sub_inc;

	function automatic line_t enter_step(seg_t s, logic [1:0] sub, logic [BIDX_W-1:0] bidx,
		line_t cur);
		line_t r;
		r = cur;
		case (s)
			SEG_START: begin
				if (sub == 2'd0) begin
					r.sda = 1'b1;
					r.scl = 1'b1;
				end else if (sub == 2'd1) begin
					r.sda = 1'b0;
				end else begin
					r.scl = 1'b0;
				end
			end
			SEG_STOP: begin
				r.sda = 1'b0;
				r.scl = 1'b1;
			end
			SEG_SEND: begin
				if (sub == 2'd0) begin
					r.sda = cur.shift[7];
				end else if (sub == 2'd1) begin
					r.scl = 1'b1;
				end else begin
					r.scl = 1'b0;
					if (bidx == LAST_BIT) r.sda = 1'b1;
					r.shift = {cur.shift[6:0], 1'b0};
				end
			end
			SEG_READ: r.scl = (sub == 2'd0);
			SEG_WACK, SEG_NACK: begin
				if (sub == 2'd0) r.sda = 1'b1;
				else r.scl = (sub == 2'd1);
			end
			default: begin
				// ack: sda low for the pulse
				if (sub == 2'd0) r.sda = 1'b0;
				else r.scl = (sub == 2'd1);
			end
		endcase
		return r;
	endfunction

	// zero hold behaves as one tick
	assign hold_m1 = (half_q == '0) ? '0 : half_q - HALF_W'(1);

	always_comb begin
		cmd_n   = cmd_q;
		phase_n = phase_q;
		sub_n   = sub_q;
		bidx_n  = bidx_q;
		tick_n  = tick_q;
		line_n  = line_q;
		ack_n   = ack_q;
		rd_n    = rd_q;
		done    = 1'b0;
		seg     = cur_seg(cmd_q, phase_q);
		sub_inc = sub_q + 2'd1;

		if (phase_q == PHASE_IDLE) begin
			if (cmd_valid) begin
				cmd_n        = cmd_t'(mode);
				line_n.shift = (cmd_t'(mode) == CMD_CHECK) ? {data[6:0], 1'b0} : data;
				phase_n      = PHASE_W'(1);
				seg          = cur_seg(cmd_n, phase_n);
				sub_n        = 2'd0;
				bidx_n       = '0;
				if (seg == SEG_READ) line_n.shift = '0;
				line_n = enter_step(seg, sub_n, bidx_n, line_n);
				tick_n = '0;
			end
		end else if (tick_q >= hold_m1) begin
			tick_n = '0;
			if (sub_inc < seg_steps(seg)) begin
				sub_n  = sub_inc;
				line_n = enter_step(seg, sub_n, bidx_n, line_n);
			end else begin
				sub_n = 2'd0;
				if ((seg == SEG_SEND || seg == SEG_READ) && bidx_q != LAST_BIT) begin
					bidx_n = bidx_q + BIDX_W'(1);
					line_n = enter_step(seg, sub_n, bidx_n, line_n);
				end else begin
					if (seg == SEG_STOP || seg == SEG_ACK) line_n.sda = 1'b1;
					if (seg == SEG_READ) rd_n = line_q.shift;
					phase_n = phase_q + PHASE_W'(1);
					if (phase_n > prog_len(cmd_q)) begin
						phase_n = PHASE_IDLE;
						bidx_n  = '0;
						done    = 1'b1;
					end else begin
						seg    = cur_seg(cmd_q, phase_n);
						bidx_n = '0;
						if (seg == SEG_READ) line_n.shift = '0;
						line_n = enter_step(seg, sub_n, bidx_n, line_n);
					end
				end
			end
		end else begin
			tick_n = tick_q + HALF_W'(1);
		end

		// sample sda on the last tick of a hold
		if (phase_n != PHASE_IDLE && tick_n >= hold_m1) begin
			seg = cur_seg(cmd_n, phase_n);
			if (seg == SEG_READ && sub_n == 2'd0) line_n.shift = {line_n.shift[6:0], sda_in};
			else if (seg == SEG_WACK && sub_n == 2'd1) ack_n = sda_in;
		end

		res_d.scl_out    = line_n.scl;
		res_d.sda_out    = line_n.sda;
		res_d.busy_res   = (phase_n != PHASE_IDLE);
		res_d.done_res   = done;
		res_d.read_byte  = rd_n;
		res_d.ack_status = ack_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
		end else if (cfg_wen) begin
			half_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_START;
			phase_q <= PHASE_IDLE;
			sub_q   <= 2'd0;
			bidx_q  <= '0;
			tick_q  <= '0;
			line_q  <= '{scl: 1'b1, sda: 1'b1, shift: 8'h00};
			ack_q   <= 1'b1;
			rd_q    <= 8'h00;
		end else if (accept) begin
			cmd_q   <= cmd_n;
			phase_q <= phase_n;
			sub_q   <= sub_n;
			bidx_q  <= bidx_n;
			tick_q  <= tick_n;
			line_q  <= line_n;
			ack_q   <= ack_n;
			rd_q    <= rd_n;
		end
	end

endmodule

// ===== sv/i2cbm_out_reg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_out_reg
// Result register: holds one result transaction until the sink takes it and
// tells the input side when a new tick can be loaded.
// ----------------------------------------------------------------------------
module i2cbm_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  i2cbm_pkg::res_t res_d,
	output logic            can_load,
	i2cbm_res_if.source     result
);
	import i2cbm_pkg::*;

	logic valid_q;
	res_t res_q;

	// free when empty or being drained this cycle
	assign can_load = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res_d;
	end

	assign result.valid      = valid_q;
	assign result.scl_out    = res_q.scl_out;
	assign result.sda_out    = res_q.sda_out;
	assign result.busy_res   = res_q.busy_res;
	assign result.done_res   = res_q.done_res;
	assign result.read_byte  = res_q.read_byte;
	assign result.ack_status = res_q.ack_status;

endmodule

// ===== sv/i2cbm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cbm_checker
// Port-level checks of the bit-level I2C master, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       t_valid,
	input logic       t_ready,
	input logic       r_valid,
	input logic       r_ready,
	input logic       r_busy,
	input logic       r_done,
	input logic       r_scl,
	input logic       r_sda,
	input logic [7:0] r_byte,
	input logic       r_ack
);

	// every accepted tick shows a result on the next clock
	a_tick_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		t_valid && t_ready |=> r_valid)
		else $error("accepted tick gave no result");

	// an empty result register never stalls the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!r_valid |-> t_ready)
		else $error("input stalled with empty result register");

	// a finished command is no longer busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_done |-> !r_busy)
		else $error("done with busy still set");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_scl) && $stable(r_sda)
			&& $stable(r_busy) && $stable(r_done) && $stable(r_byte) && $stable(r_ack))
		else $error("stalled result changed");

endmodule

bind i2c_bit_level_master_unit i2cbm_checker u_i2cbm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.t_valid (tick.valid),
	.t_ready (tick.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_busy  (result.busy_res),
	.r_done  (result.done_res),
	.r_scl   (result.scl_out),
	.r_sda   (result.sda_out),
	.r_byte  (result.read_byte),
	.r_ack   (result.ack_status)
);

// ===== tb/tb_i2c_bit_level_master_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_bit_level_master_unit
// Self-checking bench for the bit-level I2C master. A queue of tick
// transactions feeds a clocked driver. A clocked monitor runs a cycle-level
// line sequencer model on every accepted tick and checks each result
// transaction against it field by field. Stimulus: directed commands at the
// hold-length extremes, then I2C-shaped command sequences mixed with random
// noise over several hold settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_i2c_bit_level_master_unit;
	import i2cbm_pkg::*;

	typedef struct {
		logic       cv;
		logic [2:0] md;
		logic [7:0] dat;
		logic       sdi;
	} tick_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen;
	logic [15:0] cfg_wdata;

	i2cbm_tick_if tick_ch();
	i2cbm_res_if  res_ch();

	i2c_bit_level_master_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch),
		.result    (res_ch)
	);

	always #5 clk = ~clk;

	// sequencer model state
	logic [15:0] half_cfg = HALF_RESET;
	cmd_t        act_cmd = CMD_START;
	int unsigned ph = 0, sub_step = 0, bit_idx = 0, tick_cnt = 0;
	logic [7:0]  shreg = '0, rd_byte = '0;
	logic        scl = 1'b1, sda = 1'b1, ack = 1'b1;

	tick_item_t pend_q[$];
	res_t       line_q[$];
	int         n_pushed = 0, n_acc = 0, n_err = 0, n_done = 0, n_cfg = 0;
	int         n_started[8];
	bit         hold_req = 0;

	function automatic int unsigned line_hold();
		return (half_cfg == 0) ? 1 : int'(half_cfg);
	endfunction

	function automatic seg_t seg_at(cmd_t c, int unsigned p);
		seg_t s;
		s = SEG_NACK;
		if (p != 0 && p <= 5) begin
			case (c)
				CMD_START: s = SEG_START;
				CMD_STOP:  s = SEG_STOP;
				CMD_WRITE: s = SEG_SEND;
				CMD_READ:  s = SEG_READ;
				CMD_WACK:  s = SEG_WACK;
				CMD_ACK:   s = SEG_ACK;
				CMD_NACK:  s = SEG_NACK;
				default: begin
					case (p)
						1:       s = SEG_STOP;
						2:       s = SEG_START;
						3:       s = SEG_SEND;
						4:       s = SEG_WACK;
						default: s = SEG_STOP;
					endcase
				end
			endcase
		end
		return s;
	endfunction

	function automatic int unsigned steps_in(seg_t s);
		case (s)
			SEG_STOP: return 1;
			SEG_READ: return 2;
			default:  return 3;
		endcase
	endfunction

	function automatic void open_seg(seg_t s);
		sub_step = 0;
		bit_idx = 0;
		if (s == SEG_READ)
			shreg = '0;
	endfunction

	function automatic void apply_step(seg_t s);
		case (s)
			SEG_START: begin
				if (sub_step == 0) begin
					sda = 1'b1;
					scl = 1'b1;
				end else if (sub_step == 1) begin
					sda = 1'b0;
				end else begin
					scl = 1'b0;
				end
			end
			SEG_STOP: begin
				sda = 1'b0;
				scl = 1'b1;
			end
			SEG_SEND: begin
				if (sub_step == 0) begin
					sda = shreg[7];
				end else if (sub_step == 1) begin
					scl = 1'b1;
				end else begin
					scl = 1'b0;
					if (bit_idx == BITS_PER_BYTE - 1)
						sda = 1'b1;
					shreg = {shreg[6:0], 1'b0};
				end
			end
			SEG_READ: scl = (sub_step == 0);
			SEG_WACK, SEG_NACK: begin
				if (sub_step == 0)
					sda = 1'b1;
				else
					scl = (sub_step == 1);
			end
			default: begin
				if (sub_step == 0)
					sda = 1'b0;
				else
					scl = (sub_step == 1);
			end
		endcase
	endfunction

	// next line step; 1 when the command has run to its end
	function automatic logic next_step();
		seg_t s;
		s = seg_at(act_cmd, ph);
		sub_step++;
		if (sub_step < steps_in(s)) begin
			apply_step(s);
			return 1'b0;
		end
		sub_step = 0;
		if ((s == SEG_SEND || s == SEG_READ) && bit_idx + 1 < BITS_PER_BYTE) begin
			bit_idx++;
			apply_step(s);
			return 1'b0;
		end
		if (s == SEG_STOP || s == SEG_ACK)
			sda = 1'b1;
		if (s == SEG_READ)
			rd_byte = shreg;
		ph++;
		if (ph > ((act_cmd == CMD_CHECK) ? 5 : 1)) begin
			ph = 0;
			sub_step = 0;
			bit_idx = 0;
			n_done++;
			return 1'b1;
		end
		s = seg_at(act_cmd, ph);
		open_seg(s);
		apply_step(s);
		return 1'b0;
	endfunction

	function automatic res_t line_after_tick(tick_item_t it);
		res_t r;
		seg_t s;
		logic dn;
		dn = 1'b0;
		if (ph == 0) begin
			if (it.cv) begin
				act_cmd = cmd_t'(it.md);
				shreg = (act_cmd == CMD_CHECK) ? {it.dat[6:0], 1'b0} : it.dat;
				ph = 1;
				s = seg_at(act_cmd, ph);
				open_seg(s);
				apply_step(s);
				tick_cnt = 0;
				n_started[it.md]++;
			end
		end else if (tick_cnt + 1 >= line_hold()) begin
			dn = next_step();
			tick_cnt = 0;
		end else begin
			tick_cnt = (tick_cnt + 1) & 16'hFFFF;
		end
		// sample on the last tick of a hold
		if (ph != 0 && tick_cnt + 1 >= line_hold()) begin
			s = seg_at(act_cmd, ph);
			if (s == SEG_READ && sub_step == 0)
				shreg = {shreg[6:0], it.sdi};
			else if (s == SEG_WACK && sub_step == 1)
				ack = it.sdi;
		end
		r.scl_out    = scl;
		r.sda_out    = sda;
		r.busy_res   = (ph != 0);
		r.done_res   = dn;
		r.read_byte  = rd_byte;
		r.ack_status = ack;
		return r;
	endfunction

	function automatic int unsigned cmd_steps(cmd_t c);
		case (c)
			CMD_STOP:  return 1;
			CMD_WRITE: return 24;
			CMD_READ:  return 16;
			CMD_CHECK: return 32;
			default:   return 3;
		endcase
	endfunction

	// driver
	int tx_cnt = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_ch.valid     <= 1'b0;
			tick_ch.cmd_valid <= 1'b0;
			tick_ch.mode      <= CMD_START;
			tick_ch.data      <= '0;
			tick_ch.sda_in    <= 1'b1;
		end else if (!tick_ch.valid || tick_ch.ready) begin
			if (tick_ch.valid)
				tx_cnt++;
			if (pend_q.size() != 0 &&
					((tx_cnt >= 1000 && tx_cnt < 1400) || $urandom_range(0, 99) >= 9)) begin
				tick_item_t it;
				it = pend_q.pop_front();
				tick_ch.valid     <= 1'b1;
				tick_ch.cmd_valid <= it.cv;
				tick_ch.mode      <= it.md;
				tick_ch.data      <= it.dat;
				tick_ch.sda_in    <= it.sdi;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// result sink with random and one long hold-off
	int rx_cnt = 0, hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				rx_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done = 1;
				hold_left = 250;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= (rx_cnt >= 1000 && rx_cnt < 1400) ||
					($urandom_range(0, 99) >= 9);
			end
		end
	end

	task automatic report(string msg);
		if (n_err < 10)
			$display("%0t: %s", $realtime, msg);
		n_err++;
	endtask

	// monitor: check results first, then predict the tick taken at this edge
	res_t got, want;
	tick_item_t seen;
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.scl_out    = res_ch.scl_out;
				got.sda_out    = res_ch.sda_out;
				got.busy_res   = res_ch.busy_res;
				got.done_res   = res_ch.done_res;
				got.read_byte  = res_ch.read_byte;
				got.ack_status = res_ch.ack_status;
				if (line_q.size() == 0) begin
					report("result transaction with no tick pending");
				end else begin
					want = line_q.pop_front();
					if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
							got.busy_res !== want.busy_res ||
							got.done_res !== want.done_res ||
							got.read_byte !== want.read_byte ||
							got.ack_status !== want.ack_status)
						report($sformatf({"mismatch exp scl=%b sda=%b busy=%b done=%b ",
							"byte=%h ack=%b got scl=%b sda=%b busy=%b done=%b byte=%h ack=%b"},
							want.scl_out, want.sda_out, want.busy_res, want.done_res,
							want.read_byte, want.ack_status, got.scl_out, got.sda_out,
							got.busy_res, got.done_res, got.read_byte, got.ack_status));
				end
			end
			if (tick_ch.valid && tick_ch.ready) begin
				seen.cv  = tick_ch.cmd_valid;
				seen.md  = tick_ch.mode;
				seen.dat = tick_ch.data;
				seen.sdi = tick_ch.sda_in;
				line_q.push_back(line_after_tick(seen));
				n_acc++;
			end
		end
	end

	task automatic push_tick(logic cv, logic [2:0] md, logic [7:0] d, logic s);
		tick_item_t it;
		it.cv = cv;
		it.md = md;
		it.dat = d;
		it.sdi = s;
		pend_q.push_back(it);
		n_pushed++;
	endtask

	// lvl < 0 gives a random sda level on each tick
	task automatic idle_ticks(int n, int lvl);
		for (int i = 0; i < n; i++)
			push_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
				(lvl < 0) ? 1'($urandom_range(0, 1)) : 1'(lvl));
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_acc != n_pushed || line_q.size() != 0);
	endtask

	task automatic set_half(logic [15:0] v);
		wait_drained();
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		half_cfg = v;
		n_cfg++;
	endtask

	// command followed by a gap that usually lets it finish; now and then the
	// next command lands on the done tick or mid-command and is dropped
	task automatic issue(cmd_t c, logic [7:0] d);
		int span, gap, r;
		span = cmd_steps(c) * line_hold();
		r = $urandom_range(0, 15);
		if (r == 0)
			gap = span - 1;
		else if (r == 1)
			gap = span / 2;
		else
			gap = span + r % 3;
		push_tick(1'b1, c, d, 1'($urandom_range(0, 1)));
		idle_ticks(gap, -1);
	endtask

	task automatic bus_transaction();
		int n;
		if ($urandom_range(0, 4) == 0) begin
			issue(CMD_CHECK, 8'($urandom_range(0, 255)));
		end else begin
			issue(CMD_START, 8'($urandom_range(0, 255)));
			issue(CMD_WRITE, 8'($urandom_range(0, 255)));
			issue(CMD_WACK, 8'($urandom_range(0, 255)));
			n = $urandom_range(1, 3);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 1)) begin
					issue(CMD_READ, 8'($urandom_range(0, 255)));
					issue((k == n - 1) ? CMD_NACK : CMD_ACK, 8'($urandom_range(0, 255)));
				end else begin
					issue(CMD_WRITE, 8'($urandom_range(0, 255)));
					issue(CMD_WACK, 8'($urandom_range(0, 255)));
				end
			end
			issue(CMD_STOP, 8'($urandom_range(0, 255)));
		end
	endtask

	logic [15:0] phase_half[6];
	int          base;

	initial begin
		cfg_wen           <= 1'b0;
		cfg_wdata         <= '0;
		foreach (n_started[i])
			n_started[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset hold length
		push_tick(1'b1, CMD_START, 8'h00, 1'b1);
		idle_ticks(20, -1);

		// zero hold acts as one
		set_half(16'h0000);
		push_tick(1'b1, CMD_WRITE, 8'hFF, 1'b0);
		idle_ticks(30, -1);
		push_tick(1'b1, CMD_WRITE, 8'h00, 1'b1);
		idle_ticks(30, -1);
		push_tick(1'b1, CMD_READ, 8'hFF, 1'b1);
		idle_ticks(20, 1);
		push_tick(1'b1, CMD_READ, 8'h00, 1'b0);
		idle_ticks(20, 0);
		push_tick(1'b1, CMD_WACK, 8'h00, 1'b0);
		idle_ticks(6, 0);
		push_tick(1'b1, CMD_WACK, 8'hFF, 1'b1);
		idle_ticks(6, 1);
		push_tick(1'b1, CMD_ACK, 8'h55, 1'b0);
		idle_ticks(6, -1);
		push_tick(1'b1, CMD_NACK, 8'hAA, 1'b1);
		idle_ticks(6, -1);
		push_tick(1'b1, CMD_STOP, 8'h00, 1'b0);
		idle_ticks(4, -1);
		// address bit 7 is shifted out
		push_tick(1'b1, CMD_CHECK, 8'hFF, 1'b0);
		idle_ticks(40, 0);
		push_tick(1'b1, CMD_CHECK, 8'h00, 1'b1);
		idle_ticks(40, 1);
		// command while busy is dropped
		push_tick(1'b1, CMD_WRITE, 8'hA5, 1'b0);
		push_tick(1'b1, CMD_STOP, 8'h00, 1'b1);
		idle_ticks(30, -1);
		// command on the done tick is dropped too
		set_half(16'h0001);
		push_tick(1'b1, CMD_START, 8'h00, 1'b1);
		idle_ticks(2, -1);
		push_tick(1'b1, CMD_STOP, 8'h00, 1'b1);
		idle_ticks(2, -1);
		push_tick(1'b1, CMD_STOP, 8'h00, 1'b0);
		idle_ticks(4, -1);

		// longest hold, then shortened in the middle of a step
		set_half(16'hFFFF);
		push_tick(1'b1, CMD_WRITE, 8'h3C, 1'b0);
		idle_ticks(30, -1);
		set_half(16'h0001);
		idle_ticks(40, -1);

		phase_half[0] = 16'd1;
		phase_half[1] = 16'd3;
		phase_half[2] = 16'd0;
		phase_half[3] = 16'd2;
		phase_half[4] = 16'($urandom_range(1, 4));
		phase_half[5] = 16'd1;
		for (int p = 0; p < 6; p++) begin
			set_half(phase_half[p]);
			if (p == 2)
				hold_req = 1;
			base = n_pushed;
			while (n_pushed - base < 220) begin
				if ($urandom_range(0, 99) < 80) begin
					bus_transaction();
				end else begin
					repeat ($urandom_range(1, 6)) begin
						push_tick(1'b1, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
						idle_ticks($urandom_range(0, 8), -1);
					end
				end
			end
			// sender waits here for every result before the next setting
			wait_drained();
		end

		wait_drained();
		repeat (5) @(posedge clk);
		n_err += line_q.size();
		$display("covered %0d ticks across %0d hold settings, %0d commands completed",
			n_acc, n_cfg, n_done);
		$display({"started: start %0d stop %0d write %0d read %0d ",
			"ack-sample %0d ack %0d nack %0d check %0d"},
			n_started[CMD_START], n_started[CMD_STOP], n_started[CMD_WRITE],
			n_started[CMD_READ], n_started[CMD_WACK], n_started[CMD_ACK],
			n_started[CMD_NACK], n_started[CMD_CHECK]);
		if (n_err == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d errors", n_err);
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

endmodule

// ===== i2c_bit_level_master_unit.f =====
sv/i2cbm_pkg.sv
sv/i2cbm_if.sv
sv/i2cbm_seq.sv
sv/i2cbm_out_reg.sv
sv/i2c_bit_level_master_unit.sv
sv/i2cbm_checker.sv
tb/tb_i2c_bit_level_master_unit.sv
